FILE: hw/rtl/bmh_pkg.sv
// Shared types and constants for the binary max-heap block.
// Used by the controller, the datapath and the top level; depends on nothing.
package bmh_pkg;

  localparam int CAPACITY  = 1024;
  localparam int KEY_WIDTH = 32;

  // Fixed widths of the transaction fields.
  localparam int REQ_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;
  localparam int STS_W   = 2;
  localparam int OCNT_W  = 11;
  localparam int TOTAL_W = 32;

  // Internal widths derived from the capacity.
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int IDX_W  = CNT_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_POP    = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2,
    STS_RANGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_UP_READ,
    OP_UP_CMP,
    OP_POP_LOAD,
    OP_DN_READ,
    OP_DN_CMP,
    OP_RD_LOAD,
    OP_OUT_LOAD
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_UP_READ,
    S_UP_CMP,
    S_POP_LOAD,
    S_DN_READ,
    S_DN_CMP,
    S_RD_LOAD,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic pos_bad;
    logic at_root;
    logic parent_less;
    logic leaf;
    logic key_less_pick;
  } dp_stat_t;

endpackage

FILE: hw/rtl/bmh_ram.sv
// Generic RAM: one write port and two read ports with registered read data.
// Self-contained; no package dependency.
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: hw/rtl/bmh_datapath.sv
// Datapath of the binary max-heap: heap memory, entry count, sift counter,
// moving key and output registers. Depends on bmh_pkg and bmh_ram.
module bmh_datapath
  import bmh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic signed [VALUE_W-1:0] in_key,
  input  logic [POS_W-1:0]          in_position,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [STS_W-1:0]          out_status,
  output logic [OCNT_W-1:0]         out_entry_count,
  output logic [TOTAL_W-1:0]        out_sift_up_total
);

  // Request fields captured at acceptance.
  req_t                 req_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [POS_W-1:0]     pos_in_r;

  // Sift state and result.
  logic [CNT_W-1:0]     pos_r;
  logic [KEY_WIDTH-1:0] value_r;
  status_t              status_r;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  logic [VALUE_W-1:0]   out_value_r;
  status_t              out_status_r;
  logic [OCNT_W-1:0]    out_count_r;
  logic [TOTAL_W-1:0]   out_total_r;

  // Memory ports.
  logic                 we;
  logic [ADDR_W-1:0]    waddr, raddr_a, raddr_b;
  logic [KEY_WIDTH-1:0] wdata, rd_a, rd_b;

  // Navigation.
  logic [IDX_W-1:0]     lc, rc, cnt_ext, pick_idx;
  logic [CNT_W-1:0]     parent_idx;
  logic                 right_missing, pick_left;
  logic [KEY_WIDTH-1:0] pick_val;
  logic [TOTAL_W-1:0]   total_bump;
  logic                 full, empty, pos_bad, at_root, parent_less, leaf, key_less_pick;

  bmh_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (raddr_b),
    .rdata_b (rd_b)
  );

  always_comb begin
    lc            = {pos_r, 1'b0};
    rc            = lc | IDX_W'(1);
    cnt_ext       = IDX_W'(cnt_r);
    parent_idx    = pos_r >> 1;
    leaf          = lc > cnt_ext;
    right_missing = rc > cnt_ext;
    // Equal children resolve to the right child.
    pick_left     = right_missing || ($signed(rd_b) < $signed(rd_a));
    pick_val      = pick_left ? rd_a : rd_b;
    pick_idx      = pick_left ? lc : rc;
    key_less_pick = $signed(key_r) < $signed(pick_val);
    parent_less   = $signed(rd_a) < $signed(key_r);
    at_root       = pos_r == CNT_W'(1);
    full          = cnt_r >= CNT_W'(CAPACITY);
    empty         = cnt_r == '0;
    pos_bad       = (pos_in_r == '0) || (32'(pos_in_r) > 32'(cnt_r));
    total_bump    = (total_r == '1) ? total_r : total_r + TOTAL_W'(1);
  end

  assign stat = '{req:           req_r,
                  full:          full,
                  empty:         empty,
                  pos_bad:       pos_bad,
                  at_root:       at_root,
                  parent_less:   parent_less,
                  leaf:          leaf,
                  key_less_pick: key_less_pick};

  // The moving key is held in a register; the hole it leaves is filled by
  // the entry that moves past it, and the key is written once at the end.
  always_comb begin
    we      = 1'b0;
    waddr   = ADDR_W'(pos_r - CNT_W'(1));
    wdata   = key_r;
    raddr_a = '0;
    raddr_b = '0;
    case (cmd.op)
      OP_DECODE: begin
        raddr_b = ADDR_W'(cnt_r - CNT_W'(1));
        if (req_r == REQ_READ) begin
          raddr_a = ADDR_W'(pos_in_r - POS_W'(1));
        end
      end
      OP_UP_READ: begin
        raddr_a = ADDR_W'(parent_idx - CNT_W'(1));
        we      = at_root;
      end
      OP_UP_CMP: begin
        we    = 1'b1;
        wdata = parent_less ? rd_a : key_r;
      end
      OP_DN_READ: begin
        raddr_a = ADDR_W'(lc - IDX_W'(1));
        raddr_b = ADDR_W'(rc - IDX_W'(1));
        we      = leaf;
      end
      OP_DN_CMP: begin
        we    = 1'b1;
        wdata = key_less_pick ? pick_val : key_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    case (cmd.op)
      OP_DECODE: begin
        if (req_r == REQ_INSERT && !full) begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          total_nxt = total_bump;
        end else if (req_r == REQ_POP && !empty) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      OP_UP_CMP: begin
        if (parent_less) begin
          total_nxt = total_bump;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      total_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= req_t'(in_req_type);
      key_r    <= KEY_WIDTH'($signed(in_key));
      pos_in_r <= in_position;
    end
    case (cmd.op)
      OP_DECODE: begin
        value_r <= '0;
        case (req_r)
          REQ_INSERT: begin
            status_r <= full ? STS_FULL : STS_OK;
            pos_r    <= cnt_r + CNT_W'(1);
          end
          REQ_POP: begin
            status_r <= empty ? STS_EMPTY : STS_OK;
            pos_r    <= CNT_W'(1);
          end
          REQ_READ: begin
            if (empty) begin
              status_r <= STS_EMPTY;
            end else if (pos_bad) begin
              status_r <= STS_RANGE;
            end else begin
              status_r <= STS_OK;
            end
          end
          default: begin
            status_r <= STS_RANGE;
          end
        endcase
      end
      OP_UP_CMP: begin
        if (parent_less) begin
          pos_r <= parent_idx;
        end
      end
      OP_POP_LOAD: begin
        value_r <= rd_a;
        key_r   <= rd_b;
      end
      OP_DN_CMP: begin
        if (key_less_pick) begin
          pos_r <= CNT_W'(pick_idx);
        end
      end
      OP_RD_LOAD: begin
        value_r <= rd_a;
      end
      OP_OUT_LOAD: begin
        out_value_r  <= VALUE_W'(value_r);
        out_status_r <= status_r;
        out_count_r  <= OCNT_W'(cnt_r);
        out_total_r  <= total_r;
      end
      default: begin
      end
    endcase
  end

  assign out_result_value  = out_value_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;
  assign out_sift_up_total = out_total_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY)
    else $error("entry count exceeds capacity");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> total_r >= $past(total_r))
    else $error("sift-up total decreased");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_DECODE && req_r == REQ_POP && !empty) |=>
      cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("pop did not remove exactly one entry");

  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == OP_UP_CMP |-> pos_r > CNT_W'(1))
    else $error("sift-up compare issued at the root");
`endif

endmodule

FILE: hw/rtl/bmh_ctrl.sv
// Controller of the binary max-heap: sequences decode, sift steps and the
// output register handshake. Depends on bmh_pkg.
module bmh_ctrl
  import bmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = 1'b1;
    cmd.capture   = 1'b0;
    cmd.op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        unique case (stat.req)
          REQ_INSERT: state_nxt = stat.full ? S_DONE : S_UP_READ;
          REQ_POP:    state_nxt = stat.empty ? S_DONE : S_POP_LOAD;
          REQ_READ:   state_nxt = (stat.empty || stat.pos_bad) ? S_DONE : S_RD_LOAD;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_UP_READ: begin
        cmd.op    = OP_UP_READ;
        state_nxt = stat.at_root ? S_DONE : S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op    = OP_UP_CMP;
        state_nxt = stat.parent_less ? S_UP_READ : S_DONE;
      end
      S_POP_LOAD: begin
        cmd.op    = OP_POP_LOAD;
        state_nxt = S_DN_READ;
      end
      S_DN_READ: begin
        cmd.op    = OP_DN_READ;
        state_nxt = stat.leaf ? S_DONE : S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd.op    = OP_DN_CMP;
        state_nxt = stat.key_less_pick ? S_DN_READ : S_DONE;
      end
      S_RD_LOAD: begin
        cmd.op    = OP_RD_LOAD;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || !out_stall) begin
          cmd.op        = OP_OUT_LOAD;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/binary_max_heap.sv
// Top level of the binary max-heap priority queue.
// Joins bmh_ctrl and bmh_datapath; depends on bmh_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per transaction, with
//   in_req_type 0 insert in_key, 1 pop the maximum, 2 read the entry at
//   in_position (1-based). Output channel (out_valid / out_stall): exactly
//   one result per request, in order, carrying the value, status, entry
//   count after the request and the saturating sift-up total.
//   Each request runs alone. A sift step is a memory read, then a compare
//   and write. After each request the block returns to its idle state
//   before it takes the next one. A new request is taken as soon as the
//   previous one has finished, even while its result still waits in the
//   output register; when the receiver stalls, the next result holds until
//   that register is free. Reset empties the heap and clears the sift-up
//   total; no clearing pass is needed, since entries beyond the count never
//   affect a result.
module binary_max_heap
  import bmh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic signed [VALUE_W-1:0] in_key,
  input  logic [POS_W-1:0]          in_position,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [STS_W-1:0]          out_status,
  output logic [OCNT_W-1:0]         out_entry_count,
  output logic [TOTAL_W-1:0]        out_sift_up_total
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bmh_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_key            (in_key),
    .in_position       (in_position),
    .out_result_value  (out_result_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count),
    .out_sift_up_total (out_sift_up_total)
  );

endmodule

FILE: dv/bmh_checker.sv
// Checker for the binary max-heap: predicts every result from the accepted requests
// and compares it field by field with what the block returns. Depends on bmh_pkg.
module bmh_checker
  import bmh_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [REQ_W-1:0]          in_req_type,
  input  logic signed [VALUE_W-1:0] in_key,
  input  logic [POS_W-1:0]          in_position,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [VALUE_W-1:0] out_result_value,
  input  logic [STS_W-1:0]          out_status,
  input  logic [OCNT_W-1:0]         out_entry_count,
  input  logic [TOTAL_W-1:0]        out_sift_up_total,
  input  logic                      drain_check,
  output int                        fail_count
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    status_t                   status;
    logic [OCNT_W-1:0]         count;
    logic [TOTAL_W-1:0]        total;
  } heap_result_t;

  // One spare slot past the end keeps the right-child probe in range.
  logic signed [KEY_WIDTH-1:0] heap_mem [1:CAPACITY+1];
  int                          held;
  logic [TOTAL_W-1:0]          lift_total;
  heap_result_t                pending_q [$];
  bit                          drain_seen;

  function automatic void bump_lift();
    if (lift_total != '1) lift_total++;
  endfunction

  function automatic void queue_result(heap_result_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  function automatic heap_result_t apply_request(logic [REQ_W-1:0] kind,
                                                logic signed [VALUE_W-1:0] key,
                                                logic [POS_W-1:0] pos);
    heap_result_t                r;
    logic signed [KEY_WIDTH-1:0] tmp;
    int                          idx;
    int                          pick;
    bit                          moving;
    r.value  = '0;
    r.status = STS_OK;
    case (kind)
      REQ_INSERT: begin
        if (held >= CAPACITY) begin
          r.status = STS_FULL;
        end else begin
          held++;
          heap_mem[held] = key;
          bump_lift();
          idx    = held;
          moving = 1'b1;
          while (moving && idx > 1) begin
            if (heap_mem[idx/2] < heap_mem[idx]) begin
              tmp             = heap_mem[idx/2];
              heap_mem[idx/2] = heap_mem[idx];
              heap_mem[idx]   = tmp;
              bump_lift();
              idx = idx / 2;
            end else begin
              moving = 1'b0;
            end
          end
        end
      end
      REQ_POP: begin
        if (held == 0) begin
          r.status = STS_EMPTY;
        end else begin
          r.value     = heap_mem[1][VALUE_W-1:0];
          heap_mem[1] = heap_mem[held];
          held--;
          idx    = 1;
          moving = 1'b1;
          while (moving) begin
            if (2 * idx > held) begin
              moving = 1'b0;
            end else begin
              // Equal children send the entry to the right.
              if (2 * idx + 1 > held || heap_mem[2*idx+1] < heap_mem[2*idx])
                pick = 2 * idx;
              else
                pick = 2 * idx + 1;
              if (heap_mem[idx] < heap_mem[pick]) begin
                tmp            = heap_mem[idx];
                heap_mem[idx]  = heap_mem[pick];
                heap_mem[pick] = tmp;
                idx = pick;
              end else begin
                moving = 1'b0;
              end
            end
          end
        end
      end
      REQ_READ: begin
        if (held == 0)
          r.status = STS_EMPTY;
        else if (pos == 0 || pos > held)
          r.status = STS_RANGE;
        else
          r.value = heap_mem[pos][VALUE_W-1:0];
      end
      default: r.status = STS_RANGE;
    endcase
    r.count = OCNT_W'(held);
    r.total = lift_total;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    heap_result_t want;
    if (!rst_n) begin
      held       = 0;
      lift_total = '0;
      fail_count = 0;
      drain_seen = 1'b0;
      pending_q.delete();
    end else begin
      // Results are checked before the new request is queued, so a result never
      // meets the expectation of a transaction taken at the same edge.
      if (out_valid && !out_stall) begin
        if (pending_q.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d status %0d count %0d",
                   $time, out_result_value, out_status, out_entry_count);
          fail_count++;
        end else begin
          want = pending_q.pop_front();
          if (out_result_value !== want.value) begin
            $display("%0t: result_value expected %0d got %0d",
                     $time, want.value, out_result_value);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_entry_count !== want.count) begin
            $display("%0t: entry_count expected %0d got %0d",
                     $time, want.count, out_entry_count);
            fail_count++;
          end
          if (out_sift_up_total !== want.total) begin
            $display("%0t: sift_up_total expected %0d got %0d",
                     $time, want.total, out_sift_up_total);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        queue_result(apply_request(in_req_type, in_key, in_position));
      if (drain_check && !drain_seen) begin
        drain_seen = 1'b1;
        foreach (pending_q[i]) begin
          $display("%0t: missing result: value %0d status %0d count %0d",
                   $time, pending_q[i].value, pending_q[i].status, pending_q[i].count);
          fail_count++;
        end
      end
    end
  end

endmodule

FILE: dv/tb.sv
// Testbench top for binary_max_heap: drives requests, stalls the result channel
// and gives the verdict. Depends on bmh_pkg, bmh_checker and the block itself.
module tb;
  import bmh_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 30;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [REQ_W-1:0]          in_req_type = '0;
  logic signed [VALUE_W-1:0] in_key = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [VALUE_W-1:0] out_result_value;
  logic [STS_W-1:0]          out_status;
  logic [OCNT_W-1:0]         out_entry_count;
  logic [TOTAL_W-1:0]        out_sift_up_total;
  logic                      drain_check = 1'b0;
  int                        fail_count;

  int n_sent = 0;
  int n_recv = 0;
  int tracked = 0;     // entries the heap holds once every sent request is done
  int hold_ticket = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_max_heap u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_sift_up_total(out_sift_up_total)
  );

  bmh_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_key           (in_key),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_entry_count  (out_entry_count),
    .out_sift_up_total(out_sift_up_total),
    .drain_check      (drain_check),
    .fail_count       (fail_count)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) n_recv <= n_recv + 1;
  end

  // Result-side stall: short random bursts, plus one long hold per ticket.
  initial begin : stall_gen
    int burst;
    int holds_done;
    burst      = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_ticket != holds_done) begin
        holds_done = hold_ticket;
        burst      = HOLD_CYCLES;
      end else if (burst == 0 && idle_out && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 3);
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [VALUE_W-1:0] rand_key();
    int mode;
    mode = $urandom_range(0, 9);
    // A narrow band of values makes equal keys and equal children common.
    if (mode < 3) return VALUE_W'($urandom_range(0, 7)) - VALUE_W'(4);
    if (mode == 3) begin
      case ($urandom_range(0, 3))
        0:       return {1'b1, {(VALUE_W-1){1'b0}}};
        1:       return {1'b0, {(VALUE_W-1){1'b1}}};
        2:       return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    if ($urandom_range(0, 7) == 0) return POS_W'($urandom_range(0, 2047));
    return POS_W'($urandom_range(0, tracked + 1));
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(int w_ins, int w_pop, int w_rd);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return REQ_INSERT;
    if (r < w_ins + w_pop) return REQ_POP;
    if (r < w_ins + w_pop + w_rd) return REQ_READ;
    return REQ_UNUSED;
  endfunction

  // Offers one request and returns just after the edge that accepts it.
  task automatic issue(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] key,
                       input logic [POS_W-1:0] pos);
    @(negedge clk);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= kind;
    in_key      <= key;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    n_sent++;
    if (kind == REQ_INSERT && tracked < CAPACITY) tracked++;
    else if (kind == REQ_POP && tracked > 0) tracked--;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_recv != n_sent) @(negedge clk);
  endtask

  // With fill set, runs until the heap is full instead of for n transactions.
  task automatic run_mix(int n, bit fill, bit toggle, int w_ins, int w_pop, int w_rd);
    for (int i = 0; fill ? tracked < CAPACITY : i < n; i++) begin
      if (toggle && i > 0 && i % 40 == 0) begin
        idle_in  = $urandom_range(0, 1);
        idle_out = $urandom_range(0, 1);
      end
      issue(pick_kind(w_ins, w_pop, w_rd), rand_key(), rand_pos());
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty heap, unused code, key extremes, ties, range edges.
    issue(REQ_POP, '0, '0);
    issue(REQ_READ, '0, 11'd1);
    issue(REQ_UNUSED, '1, '1);
    issue(REQ_INSERT, 32'h0000_0000, '0);
    issue(REQ_INSERT, 32'h7fff_ffff, '0);
    issue(REQ_INSERT, 32'h8000_0000, '0);
    issue(REQ_INSERT, 32'hffff_ffff, '0);
    issue(REQ_INSERT, 32'd5, '0);
    issue(REQ_INSERT, 32'd5, '0);
    issue(REQ_INSERT, 32'd5, '0);
    issue(REQ_READ, '0, 11'd0);
    issue(REQ_READ, '0, 11'd1);
    issue(REQ_READ, '0, 11'd7);
    issue(REQ_READ, '0, 11'd8);
    issue(REQ_READ, '0, 11'd2047);
    issue(REQ_READ, '0, 11'd1024);
    issue(REQ_POP, '0, '0);
    issue(REQ_POP, '0, '0);
    issue(REQ_INSERT, 32'd3, '0);
    issue(REQ_INSERT, 32'd3, '0);
    issue(REQ_POP, '0, '0);
    issue(REQ_UNUSED, '0, '0);

    // Mixed traffic with a long result-side hold in the middle.
    run_mix(20, 1'b0, 1'b1, 45, 30, 20);
    hold_ticket++;
    run_mix(20, 1'b0, 1'b1, 45, 30, 20);

    // The sender waits here until every transaction so far has its result.
    idle_in  = 1'b1;
    idle_out = 1'b1;
    wait_drained();

    // Fill the heap, then push on it while full.
    run_mix(0, 1'b1, 1'b1, 97, 1, 2);
    issue(REQ_READ, '0, 11'd1024);
    repeat (6) issue(REQ_INSERT, rand_key(), '0);
    issue(REQ_READ, '0, 11'd1025);

    run_mix(40, 1'b0, 1'b1, 20, 55, 20);

    // Closing stretch runs without any idling.
    idle_in  = 1'b0;
    idle_out = 1'b0;
    run_mix(30, 1'b0, 1'b0, 40, 30, 25);

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    drain_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    if (fail_count == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
